// File: design/gap_run_length_codec_defines.svh
// Assertion macros used by the gap run-length codec RTL.
`ifndef GAP_RUN_LENGTH_CODEC_DEFINES_SVH
`define GAP_RUN_LENGTH_CODEC_DEFINES_SVH
`ifndef SYNTH
`define GRLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GRLC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GRLC_ASSERT(lbl, prop, msg)
`define GRLC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/grlc_pkg.sv
// Types and constants of the gap run-length codec.
package grlc_pkg;

  localparam int unsigned MAX_COUNT_BITS = 16;
  localparam int unsigned REP_W          = 16;
  localparam int unsigned WIDE_W         = 20;
  localparam int unsigned SUB_W          = 17;
  localparam int unsigned NUM_DIGITS     = 5;

  localparam logic [7:0] NL_BYTE    = 8'd10;
  localparam logic [7:0] HDR_BYTE   = 8'd62;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_NINE = 8'd57;
  localparam logic [7:0] GAP_RESET  = 8'd45;

  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_GAP_CHAR  = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [2:0] LAST_DIGIT_IDX = 3'd4;

  localparam logic [SUB_W-1:0] POW10 [NUM_DIGITS] = '{
    17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIGIT,
    S_GAP,
    S_BYTE
  } state_e;

endpackage

// File: design/gap_run_length_codec.sv
// Timing: a byte with one result shows it the cycle after its request is taken.
// A byte that closes a decoded run holds the input through its own cycle, S_GAP and
// S_BYTE; one that closes an encoded run holds it through its own cycle, S_DIGIT (one
// subtraction at a time over five digit places) and S_BYTE. Output stalls can hold these states.
// In encode the single 17-bit subtractor steps through powers of ten; no byte is taken meanwhile.
// Reset (rst_ni low, async) clears control, selects encode and sets the gap to '-'.
module gap_run_length_codec #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // byte requests in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  // results out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [15:0] repeat_count_o,
  output logic        last_of_item_o
);

`include "gap_run_length_codec_defines.svh"

  // Width of the run counter: never beyond the 16-bit repeat field.
  localparam int unsigned VW = (COUNT_BITS > grlc_pkg::MAX_COUNT_BITS) ?
                               grlc_pkg::MAX_COUNT_BITS : COUNT_BITS;
  localparam logic [grlc_pkg::WIDE_W-1:0] LIM_WIDE =
    {{(grlc_pkg::WIDE_W-VW){1'b0}}, {VW{1'b1}}};
  localparam logic [VW-1:0] LIM = {VW{1'b1}};

  // Configuration registers.
  logic       direction_q;
  logic [7:0] gap_char_q;

  // Parser state.
  logic          in_header_q, in_header_d;
  logic          at_line_start_q, at_line_start_d;
  logic [VW-1:0] run_value_q, run_value_d;
  logic          run_open_q, run_open_d;

  // Sequencer state for flushing a run.
  grlc_pkg::state_e state_q, state_d;
  logic [2:0]       idx_q, idx_d;
  logic [3:0]       dig_q, dig_d;
  logic             started_q, started_d;
  logic [7:0]       byte_q, byte_d;

  // Output register: holds one result while the next request may be taken.
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic [grlc_pkg::REP_W-1:0] out_rep_q, out_rep_d;
  logic                      out_last_q, out_last_d;

  logic                      out_free;
  logic                      in_fire;
  logic                      is_run_byte;
  logic                      is_digit;
  logic                      need_flush;
  logic                      digit_emit;
  logic                      load;
  logic [7:0]                load_byte;
  logic [grlc_pkg::REP_W-1:0] load_rep;
  logic                      load_last;
  logic [grlc_pkg::SUB_W-1:0]  sub_res;
  logic                      sub_ge;
  logic [grlc_pkg::WIDE_W-1:0] v_wide;
  logic [grlc_pkg::WIDE_W-1:0] dec_next;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == grlc_pkg::S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_digit    = (in_byte_i >= grlc_pkg::DIGIT_ZERO) &&
                       (in_byte_i <= grlc_pkg::DIGIT_NINE);
  assign is_run_byte = (direction_q == grlc_pkg::DIR_ENCODE) ?
                       ((in_byte_i != grlc_pkg::NL_BYTE) && (in_byte_i == gap_char_q)) :
                       is_digit;
  // A byte goes through the run path only outside headers and header openers.
  assign need_flush  = !in_header_q &&
                       !(at_line_start_q && (in_byte_i == grlc_pkg::HDR_BYTE)) &&
                       !is_run_byte && run_open_q;

  // Shared subtractor: run value against the current power of ten.
  assign sub_res = {{(grlc_pkg::SUB_W-VW){1'b0}}, run_value_q} - grlc_pkg::POW10[idx_q];
  assign sub_ge  = !sub_res[grlc_pkg::SUB_W-1];
  // Show a digit once a non-zero one has gone out, or at the units place.
  assign digit_emit = started_q || (dig_q != 4'd0) || (idx_q == grlc_pkg::LAST_DIGIT_IDX);

  // Decode accumulate: value * 10 + digit, by shift and add.
  assign v_wide   = {{(grlc_pkg::WIDE_W-VW){1'b0}}, run_value_q};
  assign dec_next = (v_wide << 3) + (v_wide << 1) +
                    {{(grlc_pkg::WIDE_W-8){1'b0}}, in_byte_i - grlc_pkg::DIGIT_ZERO};

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= grlc_pkg::DIR_ENCODE;
      gap_char_q  <= grlc_pkg::GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        grlc_pkg::REG_DIRECTION: direction_q <= cfg_data_i[0];
        grlc_pkg::REG_GAP_CHAR:  gap_char_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      grlc_pkg::S_IDLE: begin
        if (in_fire && need_flush) begin
          state_d = (direction_q == grlc_pkg::DIR_DECODE) ? grlc_pkg::S_GAP :
                                                           grlc_pkg::S_DIGIT;
        end
      end
      grlc_pkg::S_DIGIT: begin
        if (!sub_ge && digit_emit && out_free && (idx_q == grlc_pkg::LAST_DIGIT_IDX)) begin
          state_d = grlc_pkg::S_BYTE;
        end
      end
      grlc_pkg::S_GAP: begin
        if ((run_value_q == '0) || out_free) begin
          state_d = grlc_pkg::S_BYTE;
        end
      end
      grlc_pkg::S_BYTE: begin
        if (out_free) begin
          state_d = grlc_pkg::S_IDLE;
        end
      end
      default: state_d = grlc_pkg::S_IDLE;
    endcase
  end

  // Datapath and result loading.
  always_comb begin
    in_header_d     = in_header_q;
    at_line_start_d = at_line_start_q;
    run_value_d     = run_value_q;
    run_open_d      = run_open_q;
    idx_d           = idx_q;
    dig_d           = dig_q;
    started_d       = started_q;
    byte_d          = byte_q;
    load            = 1'b0;
    load_byte       = in_byte_i;
    load_rep        = grlc_pkg::REP_W'(1);
    load_last       = 1'b1;
    case (state_q)
      grlc_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_header_q) begin
            // pass header bytes; newline closes the header
            load = 1'b1;
            if (in_byte_i == grlc_pkg::NL_BYTE) begin
              in_header_d     = 1'b0;
              at_line_start_d = 1'b1;
            end
          end else if (at_line_start_q && (in_byte_i == grlc_pkg::HDR_BYTE)) begin
            in_header_d     = 1'b1;
            at_line_start_d = 1'b0;
            load            = 1'b1;
          end else begin
            at_line_start_d = (in_byte_i == grlc_pkg::NL_BYTE);
            if (is_run_byte) begin
              run_open_d = 1'b1;
              if (direction_q == grlc_pkg::DIR_ENCODE) begin
                // count the gap, saturating
                if (run_value_q != LIM) begin
                  run_value_d = run_value_q + VW'(1);
                end
              end else begin
                run_value_d = (dec_next > LIM_WIDE) ? LIM : dec_next[VW-1:0];
              end
            end else if (run_open_q) begin
              // hold the byte until the open run has gone out
              byte_d    = in_byte_i;
              idx_d     = '0;
              dig_d     = '0;
              started_d = 1'b0;
            end else begin
              load = 1'b1;
            end
          end
        end
      end
      grlc_pkg::S_DIGIT: begin
        if (sub_ge) begin
          run_value_d = sub_res[VW-1:0];
          dig_d       = dig_q + 4'd1;
        end else if (!digit_emit) begin
          // drop a leading zero
          idx_d = idx_q + 3'd1;
        end else if (out_free) begin
          load      = 1'b1;
          load_byte = grlc_pkg::DIGIT_ZERO + {4'd0, dig_q};
          load_last = 1'b0;
          started_d = 1'b1;
          dig_d     = '0;
          if (idx_q != grlc_pkg::LAST_DIGIT_IDX) begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      grlc_pkg::S_GAP: begin
        if ((run_value_q != '0) && out_free) begin
          load      = 1'b1;
          load_byte = gap_char_q;
          load_rep  = grlc_pkg::REP_W'(run_value_q);
          load_last = 1'b0;
        end
      end
      grlc_pkg::S_BYTE: begin
        if (out_free) begin
          load        = 1'b1;
          load_byte   = byte_q;
          run_value_d = '0;
          run_open_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Advance or refill the output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = load_byte;
      out_rep_d   = load_rep;
      out_last_d  = load_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= grlc_pkg::S_IDLE;
      in_header_q     <= 1'b0;
      at_line_start_q <= 1'b1;
      run_value_q     <= '0;
      run_open_q      <= 1'b0;
      idx_q           <= '0;
      dig_q           <= '0;
      started_q       <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      in_header_q     <= in_header_d;
      at_line_start_q <= at_line_start_d;
      run_value_q     <= run_value_d;
      run_open_q      <= run_open_d;
      idx_q           <= idx_d;
      dig_q           <= dig_d;
      started_q       <= started_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign repeat_count_o = out_rep_q;
  assign last_of_item_o = out_last_q;

  `GRLC_ASSERT(a_closed_run_empty, (!run_open_q |-> (run_value_q == '0)), "closed run holds a count")
  `GRLC_ASSERT(a_header_not_start, (in_header_q |-> !at_line_start_q), "header at line start")
  `GRLC_ASSERT(a_digit_range, ((state_q == grlc_pkg::S_DIGIT) |-> (dig_q <= 4'd9)), "digit above nine")
  `GRLC_ASSERT(a_digit_idx, ((state_q == grlc_pkg::S_DIGIT) |-> (idx_q <= grlc_pkg::LAST_DIGIT_IDX)), "digit place out of range")
  `GRLC_ASSERT_RST(a_reset_quiet, (!rst_ni |-> !out_valid_o), "result shown in reset")

endmodule
